// ===== hw/rtl/bff_pkg.sv =====
// shared types, codes and constants of the best-fit free list
package bff_pkg;

  localparam int unsigned BffEntries = 16;
  localparam int unsigned OffsetW    = 32;
  localparam int unsigned SizeW      = 16;

  typedef enum logic {
    ACT_RELEASE = 1'b0,
    ACT_ALLOC   = 1'b1
  } bff_action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2
  } bff_status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SEARCH,
    FSM_DONE
  } bff_state_e;

  typedef struct packed {
    bff_action_e        action;
    logic [OffsetW-1:0] block_offset;
    logic [SizeW-1:0]   block_size;
  } req_t;

  typedef struct packed {
    bff_status_e        status;
    logic [OffsetW-1:0] granted_offset;
    logic [SizeW-1:0]   granted_size;
  } rsp_t;

  typedef struct packed {
    logic               occ;
    logic [OffsetW-1:0] offset;
    logic [SizeW-1:0]   size;
  } entry_t;

  typedef struct packed {
    logic               found;
    logic [OffsetW-1:0] offset;
    logic [SizeW-1:0]   size;
  } tok_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/bff_stream_if.sv =====
// valid/ready channel carrying one payload item
interface bff_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/bff_cell.sv =====
// one list cell: holds an entry, forwards the best-fit token, shifts on removal
module bff_cell import bff_pkg::*; #(
  parameter int unsigned      IDX_W = 4,
  parameter logic [IDX_W-1:0] IDX   = '0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic [OffsetW-1:0] wr_offset_i,
  input  logic [SizeW-1:0]   wr_size_i,
  input  entry_t             next_entry_i,
  output entry_t             entry_o,
  input  logic [SizeW-1:0]   req_size_i,
  input  tok_t               tok_i,
  input  logic [IDX_W-1:0]   tok_idx_i,
  output tok_t               tok_o,
  output logic [IDX_W-1:0]   tok_idx_o
);

  logic               occ_q, occ_d;
  logic [OffsetW-1:0] off_q, off_d;
  logic [SizeW-1:0]   size_q, size_d;
  logic               tok_found_q;
  logic [OffsetW-1:0] tok_off_q;
  logic [SizeW-1:0]   tok_size_q;
  logic [IDX_W-1:0]   tok_idx_q;
  logic               take;
  tok_t               tok_d;
  logic [IDX_W-1:0]   tok_idx_d;

  always_comb begin
    priority if (ctrl_i.shift) begin
      occ_d  = next_entry_i.occ;
      off_d  = next_entry_i.offset;
      size_d = next_entry_i.size;
    end else if (ctrl_i.load) begin
      occ_d  = 1'b1;
      off_d  = wr_offset_i;
      size_d = wr_size_i;
    end else begin
      occ_d  = occ_q;
      off_d  = off_q;
      size_d = size_q;
    end
  end

  // earliest entry wins ties: only a strictly smaller size replaces the token
  assign take = occ_q && (size_q >= req_size_i) && (!tok_i.found || (size_q < tok_i.size));

  always_comb begin
    if (take) begin
      tok_d     = '{found: 1'b1, offset: off_q, size: size_q};
      tok_idx_d = IDX;
    end else begin
      tok_d     = tok_i;
      tok_idx_d = tok_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= 1'b0;
      tok_found_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      tok_found_q <= tok_d.found;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q      <= off_d;
    size_q     <= size_d;
    tok_off_q  <= tok_d.offset;
    tok_size_q <= tok_d.size;
    tok_idx_q  <= tok_idx_d;
  end

  assign entry_o   = '{occ: occ_q, offset: off_q, size: size_q};
  assign tok_o     = '{found: tok_found_q, offset: tok_off_q, size: tok_size_q};
  assign tok_idx_o = tok_idx_q;

endmodule

// ===== hw/rtl/best_fit_free_list_top.sv =====
// best-fit free list: control, response register and the chain of list cells
//
//   channel | dir | payload                                      | item
//   req_i   | in  | action, block_offset, block_size             | one request
//   rsp_o   | out | status, granted_offset, granted_size         | one response
//
// a release is applied and answered at its accept edge
// an allocate walks the best-fit token along the cell chain
//   one cell per cycle, then the winner is answered and later cells shift up
// reset empties the list at once through per-cell occupied bits
// one request at a time; req_i is ready in idle while the response register is free
module best_fit_free_list_top import bff_pkg::*; #(
  parameter int unsigned ENTRIES = BffEntries
) (
  input logic           clk_i,
  input logic           rst_ni,
  bff_stream_if.sink    req_i,
  bff_stream_if.source  rsp_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(ENTRIES);

  bff_state_e       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] scnt_q, scnt_d;
  logic [SizeW-1:0] req_size_q;
  logic             rsp_valid_q, rsp_valid_d;
  rsp_t             rsp_data_q, rsp_data_d;
  logic             accept, is_release, full, append, remove, rsp_load;
  req_t             req;

  entry_t           entry_w [ENTRIES];
  tok_t             tok_w   [ENTRIES+1];
  logic [IDX_W-1:0] idx_w   [ENTRIES+1];
  cell_ctrl_t       ctrl_w  [ENTRIES];

  assign req        = req_i.data;
  assign req_i.ready = (state_q == FSM_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept     = req_i.valid && req_i.ready;
  assign is_release = (req.action == ACT_RELEASE);
  assign full       = (count_q == FullCnt);
  assign append     = accept && is_release && !full;
  assign remove     = (state_q == FSM_DONE) && tok_w[ENTRIES].found;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept && !is_release) state_d = FSM_SEARCH;
      end
      FSM_SEARCH: begin
        if (scnt_q == LastIdx) state_d = FSM_DONE;
      end
      FSM_DONE: begin
        state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    scnt_d     = scnt_q;
    count_d    = count_q;
    rsp_load   = 1'b0;
    rsp_data_d = rsp_data_q;
    unique case (state_q)
      FSM_IDLE: begin
        scnt_d = '0;
        if (accept && is_release) begin
          rsp_load   = 1'b1;
          rsp_data_d = '{status: full ? ST_FULL : ST_OK, granted_offset: '0,
                         granted_size: '0};
          if (!full) count_d = count_q + CNT_W'(1);
        end
      end
      FSM_SEARCH: begin
        scnt_d = scnt_q + IDX_W'(1);
      end
      FSM_DONE: begin
        rsp_load = 1'b1;
        if (tok_w[ENTRIES].found) begin
          rsp_data_d = '{status: ST_OK, granted_offset: tok_w[ENTRIES].offset,
                         granted_size: tok_w[ENTRIES].size};
          count_d    = count_q - CNT_W'(1);
        end else begin
          rsp_data_d = '{status: ST_NO_FIT, granted_offset: '0, granted_size: '0};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (rsp_load)         rsp_valid_d = 1'b1;
    else if (rsp_o.ready) rsp_valid_d = 1'b0;
    else                  rsp_valid_d = rsp_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      scnt_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scnt_q      <= scnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_data_q <= rsp_data_d;
    if (accept) req_size_q <= req.block_size;
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

  assign tok_w[0] = '0;
  assign idx_w[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t next_entry;

    assign ctrl_w[i].load  = append && (count_q == CNT_W'(i));
    assign ctrl_w[i].shift = remove && (IDX_W'(i) >= idx_w[ENTRIES]);

    if (i == ENTRIES - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end

    bff_cell #(
      .IDX_W (IDX_W),
      .IDX   (IDX_W'(i))
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_w[i]),
      .wr_offset_i  (req.block_offset),
      .wr_size_i    (req.block_size),
      .next_entry_i (next_entry),
      .entry_o      (entry_w[i]),
      .req_size_i   (req_size_q),
      .tok_i        (tok_w[i]),
      .tok_idx_i    (idx_w[i]),
      .tok_o        (tok_w[i+1]),
      .tok_idx_o    (idx_w[i+1])
    );
  end

endmodule
